/* rtl/core/bsc_pkg.sv */
// Shared widths for the barometer compensation block.
package bsc_pkg;

  localparam int RAW_W      = 24;  // raw conversion word
  localparam int COEF_W     = 16;  // calibration word
  localparam int RES_W      = 32;  // result fields
  localparam int CFG_ADDR_W = 3;   // register index

endpackage

/* rtl/core/bsc_intf.sv */
// Valid/ready channels for raw samples and compensated results.
interface bsc_sample_if;
  logic                              valid;
  logic                              ready;
  logic [bsc_pkg::RAW_W-1:0]         pressure_raw;
  logic [bsc_pkg::RAW_W-1:0]         temperature_raw;

  modport source (output valid, output pressure_raw, output temperature_raw, input ready);
  modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface bsc_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [bsc_pkg::RES_W-1:0]  temperature_centideg;
  logic signed [bsc_pkg::RES_W-1:0]  pressure_pa;
  logic signed [bsc_pkg::RES_W-1:0]  pressure_smoothed;

  modport source (output valid, output temperature_centideg, output pressure_pa,
                  output pressure_smoothed, input ready);
  modport sink   (input valid, input temperature_centideg, input pressure_pa,
                  input pressure_smoothed, output ready);
endinterface

/* rtl/core/baro_sensor_compensation.sv */
// One sample is in work at a time: the sequencer takes a new beat only from idle and
//   steps the one shared 26x26 signed multiplier; it holds before the output register
//   until the previous result has been taken.
// A sample is accepted while the previous result still waits in the output register.
// Reset (rst, synchronous, active high): calibration words and the smoothing
//   history go to zero, the sequencer to idle, the output register empty.
module baro_sensor_compensation (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bsc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bsc_pkg::COEF_W-1:0]        cfg_data,
  bsc_sample_if.sink                        sample,
  bsc_result_if.source                      result
);

  // Calibration register indexes
  localparam logic [bsc_pkg::CFG_ADDR_W-1:0] REG_C1 = 3'd0;  // pressure sensitivity
  localparam logic [bsc_pkg::CFG_ADDR_W-1:0] REG_C2 = 3'd1;  // pressure offset
  localparam logic [bsc_pkg::CFG_ADDR_W-1:0] REG_C3 = 3'd2;  // TC of sensitivity
  localparam logic [bsc_pkg::CFG_ADDR_W-1:0] REG_C4 = 3'd3;  // TC of offset
  localparam logic [bsc_pkg::CFG_ADDR_W-1:0] REG_C5 = 3'd4;  // reference temperature
  localparam logic [bsc_pkg::CFG_ADDR_W-1:0] REG_C6 = 3'd5;  // TC of temperature

  localparam logic signed [19:0] T_REF = 20'sd2000;  // 20.00 C

  typedef enum logic [3:0] {
    ST_IDLE,      // wait for a sample beat
    ST_DT,        // dT = D2 - C5*256
    ST_MUL_TS,    // dT*C6
    ST_MUL_OFF,   // T = 2000 + (dT*C6 >> 23); start C4*dT
    ST_MUL_SENS,  // OFF = C2<<17 + (C4*dT >> 6); start C3*dT
    ST_MUL_DSQ,   // SENS = C1<<16 + (C3*dT >> 7); start D*D
    ST_MUL_DTSQ,  // latch D^2; start dT*dT
    ST_CORR,      // second-order T and SENS, 61*D^2
    ST_CORR_OFF,  // second-order OFF
    ST_PLO,       // D1 * SENS low part
    ST_PHI,       // D1 * SENS high part
    ST_PACC,      // combine partial products
    ST_PRES,      // P = ((D1*SENS >> 21) - OFF) >> 15
    ST_SMOOTH,    // 7*P + previous
    ST_OUT        // load output register once it is free
  } state_t;

  state_t state;

  logic [bsc_pkg::COEF_W-1:0] c1, c2, c3, c4, c5, c6;

  logic [bsc_pkg::RAW_W-1:0]  d1, d2;
  logic signed [24:0]         dt;
  logic signed [19:0]         t;
  logic signed [39:0]         off, sens;
  logic [35:0]                sq;
  logic [39:0]                m61;
  logic signed [63:0]         acc;
  logic [31:0]                p, sum, prev;
  logic                       low;

  // Shared multiplier, product registered every cycle
  logic signed [25:0]         mul_a, mul_b;
  logic signed [51:0]         mul_p, prod;

  logic signed [19:0]         dlt;
  logic signed [47:0]         diff;
  logic signed [32:0]         adj;

  assign mul_p = mul_a * mul_b;
  assign dlt   = t - T_REF;
  assign diff  = {{5{acc[63]}}, acc[63:21]} - {{8{off[39]}}, off};
  // truncate toward zero: bias negatives by 7 before the shift
  assign adj   = {sum[31], sum} + (sum[31] ? 33'sd7 : 33'sd0);

  always_comb begin
    mul_a = {{1{dt[24]}}, dt};
    mul_b = '0;
    case (state)
      ST_MUL_TS:   mul_b = {10'd0, c6};
      ST_MUL_OFF:  mul_b = {10'd0, c4};
      ST_MUL_SENS: mul_b = {10'd0, c3};
      ST_MUL_DSQ: begin
        mul_a = {{6{dlt[19]}}, dlt};
        mul_b = {{6{dlt[19]}}, dlt};
      end
      ST_MUL_DTSQ: mul_b = {{1{dt[24]}}, dt};
      ST_PLO: begin
        mul_a = {2'd0, d1};
        mul_b = {7'd0, sens[18:0]};
      end
      ST_PHI: begin
        mul_a = {2'd0, d1};
        mul_b = {{5{sens[39]}}, sens[39:19]};
      end
      default: mul_b = '0;
    endcase
  end

  assign sample.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
      prev         <= '0;
      c1 <= '0; c2 <= '0; c3 <= '0; c4 <= '0; c5 <= '0; c6 <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_C1:  c1 <= cfg_data;
          REG_C2:  c2 <= cfg_data;
          REG_C3:  c3 <= cfg_data;
          REG_C4:  c4 <= cfg_data;
          REG_C5:  c5 <= cfg_data;
          REG_C6:  c6 <= cfg_data;
          default: ;  // unmapped index, dropped
        endcase
      end

      // ST_OUT drives valid itself when it reloads the register
      if (result.valid && result.ready && state != ST_OUT) result.valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            d1    <= sample.pressure_raw;
            d2    <= sample.temperature_raw;
            state <= ST_DT;
          end
        end
        ST_DT: begin
          dt    <= $signed({1'b0, d2}) - $signed({1'b0, c5, 8'd0});
          state <= ST_MUL_TS;
        end
        ST_MUL_TS: state <= ST_MUL_OFF;
        ST_MUL_OFF: begin
          t     <= prod[42:23] + T_REF;
          state <= ST_MUL_SENS;
        end
        ST_MUL_SENS: begin
          off   <= $signed({7'd0, c2, 17'd0}) + prod[45:6];
          state <= ST_MUL_DSQ;
        end
        ST_MUL_DSQ: begin
          sens  <= $signed({8'd0, c1, 16'd0}) + prod[46:7];
          low   <= dlt[19];
          state <= ST_MUL_DTSQ;
        end
        ST_MUL_DTSQ: begin
          sq    <= prod[35:0];
          state <= ST_CORR;
        end
        ST_CORR: begin
          if (low) begin
            t    <= t - $signed(prod[50:31]);
            sens <= sens - $signed({2'd0, sq, 2'd0});
          end
          m61   <= ({4'd0, sq} << 6) - ({4'd0, sq} << 1) - {4'd0, sq};
          state <= ST_CORR_OFF;
        end
        ST_CORR_OFF: begin
          if (low) off <= off - $signed({4'd0, m61[39:4]});
          state <= ST_PLO;
        end
        ST_PLO: state <= ST_PHI;
        ST_PHI: begin
          acc   <= {{12{prod[51]}}, prod};
          state <= ST_PACC;
        end
        ST_PACC: begin
          acc   <= acc + ({{12{prod[51]}}, prod} << 19);
          state <= ST_PRES;
        end
        ST_PRES: begin
          p     <= diff[46:15];
          state <= ST_SMOOTH;
        end
        ST_SMOOTH: begin
          sum   <= {p[28:0], 3'd0} - p + prev;
          state <= ST_OUT;
        end
        ST_OUT: begin
          // hold here until the previous result beat has gone
          if (!result.valid || result.ready) begin
            result.valid                <= 1'b1;
            result.temperature_centideg <= {{12{t[19]}}, t};
            result.pressure_pa          <= p;
            result.pressure_smoothed    <= {{2{adj[32]}}, adj[32:3]};
            prev                        <= p;
            state                       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/bsc_checker.sv */
// Port-level checks for the barometer compensation block, bound into that module.
module bsc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [bsc_pkg::RES_W-1:0]  out_temp,
  input logic signed [bsc_pkg::RES_W-1:0]  out_pres,
  input logic signed [bsc_pkg::RES_W-1:0]  out_smooth
);

  logic       in_beat, out_beat;
  logic [1:0] pending;  // samples taken, results not yet delivered

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_beat} - {1'b0, out_beat};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_temp) && $stable(out_pres)
                                && $stable(out_smooth))
    else $error("result beat changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !in_ready)
    else $error("sample taken while previous one still in work");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> pending != 2'd0)
    else $error("result beat without a pending sample");

  a_two_deep: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> !in_ready)
    else $error("more than two samples in flight");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample.valid),
  .in_ready   (sample.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_temp   (result.temperature_centideg),
  .out_pres   (result.pressure_pa),
  .out_smooth (result.pressure_smoothed)
);
